// ===== hw/rtl/brm_pkg.sv =====
package brm_pkg;

    localparam int RAM_BYTES_DEF = 128;

    typedef enum logic [1:0] {
        ACT_CPU_READ  = 2'd0,
        ACT_CPU_WRITE = 2'd1,
        ACT_PRG_MAP   = 2'd2,
        ACT_PPU_MAP   = 2'd3
    } action_t;

    localparam logic [1:0] CFG_ALT_MODE = 2'd0;
    localparam logic [1:0] CFG_PRG_MASK = 2'd1;
    localparam logic [1:0] CFG_CHR_MASK = 2'd2;

    localparam logic [7:0]  UNLOCK_KEY = 8'hA3;
    localparam logic [7:0]  RAM_PAGE   = 8'h7F;
    localparam logic [11:0] REG_PAGE   = 12'h7EF;

    localparam logic [3:0] REG_TILE_FIRST  = 4'h0;
    localparam logic [3:0] REG_TILE_LAST   = 4'h5;
    localparam logic [3:0] REG_MIRROR_H    = 4'h6;
    localparam logic [3:0] REG_MIRROR_V    = 4'h7;
    localparam logic [3:0] REG_KEY_A       = 4'h8;
    localparam logic [3:0] REG_KEY_B       = 4'h9;
    localparam logic [3:0] REG_PRG_FIRST   = 4'hA;
    localparam logic [3:0] REG_PRG_LAST    = 4'hF;

    localparam int TILE_REGS = 6;
    localparam int PRG_REGS  = 3;

    localparam logic [7:0] PRG_MASK_RST = 8'h3F;
    localparam logic [7:0] CHR_MASK_RST = 8'hFF;

    typedef struct packed {
        action_t     action;
        logic [15:0] addr;
        logic [7:0]  data;
    } item_t;

    typedef struct packed {
        logic re;
        logic we;
    } ram_req_t;

    typedef struct packed {
        logic        read_driven;
        logic [18:0] mapped_address;
        logic        mapped_valid;
        logic        nametable_page;
        logic        is_nametable;
    } result_t;

endpackage

// ===== hw/rtl/brm_ram.sv =====
module brm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/brm_map.sv =====
module brm_map (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  brm_pkg::item_t    item,
    input  logic              advance,
    output brm_pkg::ram_req_t ram_req,
    output brm_pkg::result_t  result
);

    logic       alt_mode_reg;
    logic [5:0] prg_mask_reg;
    logic [7:0] chr_mask_reg;

    logic [7:0] tile_bank_reg [brm_pkg::TILE_REGS];
    logic [7:0] tile_bank_next [brm_pkg::TILE_REGS];
    logic [7:0] prg_bank_reg [brm_pkg::PRG_REGS];
    logic [7:0] prg_bank_next [brm_pkg::PRG_REGS];
    logic [7:0] key_reg;
    logic [7:0] key_next;
    logic       mirror_v_reg;
    logic       mirror_v_next;
    logic [1:0] pair_page_reg;
    logic [1:0] pair_page_next;

    logic       ram_open;
    logic       reg_hit;
    logic [3:0] reg_lo;
    logic [3:0] prg_off;
    logic [2:0] tile_idx;
    logic [5:0] prg_bank;
    logic [7:0] chr_bank;
    logic [1:0] quad;

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_mode_reg <= 1'b0;
            prg_mask_reg <= brm_pkg::PRG_MASK_RST[5:0];
            chr_mask_reg <= brm_pkg::CHR_MASK_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                brm_pkg::CFG_ALT_MODE: alt_mode_reg <= cfg_data[0];
                brm_pkg::CFG_PRG_MASK: prg_mask_reg <= cfg_data[5:0];
                brm_pkg::CFG_CHR_MASK: chr_mask_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    assign ram_open = (item.addr[15:8] == brm_pkg::RAM_PAGE) && (key_reg == brm_pkg::UNLOCK_KEY);
    assign reg_hit  = (item.addr[15:4] == brm_pkg::REG_PAGE);
    assign reg_lo   = item.addr[3:0];
    assign prg_off  = reg_lo - brm_pkg::REG_PRG_FIRST;

    assign ram_req.we = advance && (item.action == brm_pkg::ACT_CPU_WRITE) && ram_open;
    assign ram_req.re = advance && (item.action == brm_pkg::ACT_CPU_READ) && ram_open;

    // bank register writes
    always_comb
    begin
        tile_bank_next = tile_bank_reg;
        prg_bank_next  = prg_bank_reg;
        key_next       = key_reg;
        mirror_v_next  = mirror_v_reg;
        pair_page_next = pair_page_reg;
        if (advance && (item.action == brm_pkg::ACT_CPU_WRITE) && !ram_open && reg_hit)
        begin
            case (reg_lo) inside
                [brm_pkg::REG_TILE_FIRST:brm_pkg::REG_TILE_LAST]:
                begin
                    tile_bank_next[reg_lo[2:0]] = item.data;
                    if (alt_mode_reg && (reg_lo[3:1] == 3'd0))
                    begin
                        pair_page_next[reg_lo[0]] = item.data[7];
                    end
                end
                brm_pkg::REG_MIRROR_H, brm_pkg::REG_MIRROR_V:
                begin
                    if (!alt_mode_reg)
                    begin
                        mirror_v_next = item.data[0];
                    end
                end
                brm_pkg::REG_KEY_A, brm_pkg::REG_KEY_B:
                begin
                    key_next = item.data;
                end
                [brm_pkg::REG_PRG_FIRST:brm_pkg::REG_PRG_LAST]:
                begin
                    prg_bank_next[prg_off[2:1]] = item.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < brm_pkg::TILE_REGS; i++)
            begin
                tile_bank_reg[i] <= 8'h00;
            end
            for (int i = 0; i < brm_pkg::PRG_REGS; i++)
            begin
                prg_bank_reg[i] <= 8'h00;
            end
            key_reg       <= 8'h00;
            mirror_v_reg  <= 1'b0;
            pair_page_reg <= 2'b00;
        end
        else
        begin
            tile_bank_reg <= tile_bank_next;
            prg_bank_reg  <= prg_bank_next;
            key_reg       <= key_next;
            mirror_v_reg  <= mirror_v_next;
            pair_page_reg <= pair_page_next;
        end
    end

    // address translation
    assign prg_bank = (item.addr[14:13] == 2'd3) ? prg_mask_reg
                    : (prg_bank_reg[item.addr[14:13]][5:0] & prg_mask_reg);

    assign tile_idx = {1'b0, item.addr[11:10]} + 3'd2;

    always_comb
    begin
        if (!item.addr[12])
        begin
            chr_bank = {tile_bank_reg[{2'b00, item.addr[11]}][7:1], item.addr[10]};
        end
        else
        begin
            chr_bank = tile_bank_reg[tile_idx];
        end
        chr_bank = chr_bank & chr_mask_reg;
    end

    assign quad = item.addr[11:10];

    always_comb
    begin
        result = '0;
        case (item.action)
            brm_pkg::ACT_CPU_READ:
            begin
                result.read_driven = ram_open;
            end
            brm_pkg::ACT_CPU_WRITE:
            begin
            end
            brm_pkg::ACT_PRG_MAP:
            begin
                if (item.addr[15])
                begin
                    result.mapped_address = {prg_bank, item.addr[12:0]};
                    result.mapped_valid   = 1'b1;
                end
            end
            brm_pkg::ACT_PPU_MAP:
            begin
                if (item.addr[15:13] == 3'd0)
                begin
                    result.mapped_address = {1'b0, chr_bank, item.addr[9:0]};
                    result.mapped_valid   = 1'b1;
                end
                else if (item.addr < 16'h3F00)
                begin
                    result.is_nametable = 1'b1;
                    if (alt_mode_reg)
                    begin
                        result.nametable_page = pair_page_reg[quad[1]];
                    end
                    else if (mirror_v_reg)
                    begin
                        result.nametable_page = quad[0];
                    end
                    else
                    begin
                        result.nametable_page = quad[1];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/banked_rom_mapper_with_keyed_ram.sv =====
// Bank mapper with keyed work RAM. One beat in, one beat out; a new beat can be
// taken every cycle unless out_stall holds the output, via an input register,
// then a result register whose read data comes from the work RAM's registered
// read port. Register and RAM writes take effect in order, so every beat sees
// all effects of the beats before it. Work RAM contents read as zero until an
// entry is written after reset; per-entry valid flops clear at once, no sweep.
module banked_rom_mapper_with_keyed_ram #(
    parameter int RAM_BYTES = brm_pkg::RAM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        read_driven,
    output logic [18:0] mapped_address,
    output logic        mapped_valid,
    output logic        nametable_page,
    output logic        is_nametable,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int RAM_AW = $clog2(RAM_BYTES);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    brm_pkg::item_t    s1_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    brm_pkg::result_t  out_res_reg;
    logic              out_ent_valid_reg;

    logic              advance;
    logic              in_accept;
    brm_pkg::ram_req_t ram_req;
    brm_pkg::result_t  result;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        ram_rdata;
    logic [RAM_BYTES-1:0] ent_valid_reg;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ent_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (ram_req.we)
            begin
                ent_valid_reg[ram_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.action <= brm_pkg::action_t'(action);
            s1_item_reg.addr   <= bus_address;
            s1_item_reg.data   <= write_data;
        end
        if (advance)
        begin
            out_res_reg       <= result;
            out_ent_valid_reg <= ent_valid_reg[ram_addr];
        end
    end

    assign ram_addr = s1_item_reg.addr[RAM_AW-1:0];

    brm_map u_map (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (s1_item_reg),
        .advance      (advance),
        .ram_req      (ram_req),
        .result       (result)
    );

    brm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_wram (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_addr),
        .wdata (s1_item_reg.data),
        .rdata (ram_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign read_data      = (out_res_reg.read_driven && out_ent_valid_reg) ? ram_rdata : 8'h00;
    assign read_driven    = out_res_reg.read_driven;
    assign mapped_address = out_res_reg.mapped_address;
    assign mapped_valid   = out_res_reg.mapped_valid;
    assign nametable_page = out_res_reg.nametable_page;
    assign is_nametable   = out_res_reg.is_nametable;

endmodule
